[hdl/ras_pkg.sv]
// shared constants, types, arithmetic helpers and microcode table of the roessler step block
package ras_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 24;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int STEP_WIDTH  = 4;
   localparam int CSR_ADDR_WIDTH = 4;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic [STEP_WIDTH-1:0]         step_type;

   localparam value_type VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // reset values, Q8.24
   localparam value_type COEF_A_RESET    = 32'sd335544;
   localparam value_type COEF_B_RESET    = 32'sd335544;
   localparam value_type COEF_C_RESET    = 32'sd95630131;
   localparam value_type TIME_STEP_RESET = 32'sd838861;
   localparam value_type POINT_RESET     = 32'sd167772;

   // register indexes
   localparam logic [1:0] REG_COEF_A    = 2'd0;
   localparam logic [1:0] REG_COEF_B    = 2'd1;
   localparam logic [1:0] REG_COEF_C    = 2'd2;
   localparam logic [1:0] REG_TIME_STEP = 2'd3;

   // alu operations
   localparam logic [1:0] OP_NOP = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_ADD = 2'd2;
   localparam logic [1:0] OP_NEG = 2'd3;

   // operand sources
   localparam logic [3:0] SRC_ZERO = 4'd0;
   localparam logic [3:0] SRC_X    = 4'd1;
   localparam logic [3:0] SRC_Y    = 4'd2;
   localparam logic [3:0] SRC_Z    = 4'd3;
   localparam logic [3:0] SRC_A    = 4'd4;
   localparam logic [3:0] SRC_B    = 4'd5;
   localparam logic [3:0] SRC_C    = 4'd6;
   localparam logic [3:0] SRC_H    = 4'd7;
   localparam logic [3:0] SRC_T0   = 4'd8;
   localparam logic [3:0] SRC_T1   = 4'd9;
   localparam logic [3:0] SRC_T2   = 4'd10;
   localparam logic [3:0] SRC_P    = 4'd11;

   // destinations
   localparam logic [2:0] DST_NONE = 3'd0;
   localparam logic [2:0] DST_X    = 3'd1;
   localparam logic [2:0] DST_Y    = 3'd2;
   localparam logic [2:0] DST_Z    = 3'd3;
   localparam logic [2:0] DST_T0   = 3'd4;
   localparam logic [2:0] DST_T1   = 3'd5;
   localparam logic [2:0] DST_T2   = 3'd6;

   // jump conditions: jump to target when true, else fall through
   localparam logic [1:0] JC_NEVER    = 2'd0;
   localparam logic [1:0] JC_NO_START = 2'd1;
   localparam logic [1:0] JC_OUT_BUSY = 2'd2;

   typedef struct packed {
      logic [1:0] alu_op;
      logic [3:0] src_a;
      logic [3:0] src_b;
      logic [2:0] dst;
      logic [1:0] cond;
      step_type   target;
      logic       emit;
   } ctrl_word_type;

   typedef struct packed {
      value_type coef_a;
      value_type coef_b;
      value_type coef_c;
      value_type time_step;
   } coef_set_type;

   function automatic value_type sat_wide(input logic signed [VALUE_WIDTH:0] v);
      value_type r;
      if (v > $signed({VMAX[VALUE_WIDTH-1], VMAX})) r = VMAX;
      else if (v < $signed({VMIN[VALUE_WIDTH-1], VMIN})) r = VMIN;
      else r = v[VALUE_WIDTH-1:0];
      return r;
   endfunction

   function automatic value_type sat_add(input value_type a, input value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      return sat_wide(s);
   endfunction

   function automatic value_type sat_neg(input value_type a);
      logic signed [VALUE_WIDTH:0] s;
      s = -{a[VALUE_WIDTH-1], a};
      return sat_wide(s);
   endfunction

   // floor(p / 2^FRAC_BITS), clamped
   function automatic value_type sat_prod(input prod_type p);
      prod_type q;
      value_type r;
      q = p >>> FRAC_BITS;
      if (q > prod_type'(VMAX)) r = VMAX;
      else if (q < prod_type'(VMIN)) r = VMIN;
      else r = q[VALUE_WIDTH-1:0];
      return r;
   endfunction

   // microcode: t1 = dy, t0 = dx, t2 = dz, then x, y, z += h * d
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '{alu_op: OP_NOP, src_a: SRC_ZERO, src_b: SRC_ZERO, dst: DST_NONE,
            cond: JC_NEVER, target: '0, emit: 1'b0};
      case (step)
         4'd0: begin
            w.cond   = JC_NO_START;
            w.target = 4'd0;
         end
         4'd1: begin
            w.alu_op = OP_MUL; w.src_a = SRC_A; w.src_b = SRC_Y;
         end
         4'd2: begin
            w.alu_op = OP_ADD; w.src_a = SRC_X; w.src_b = SRC_P; w.dst = DST_T1;
         end
         4'd3: begin
            w.alu_op = OP_ADD; w.src_a = SRC_Y; w.src_b = SRC_Z; w.dst = DST_T0;
         end
         4'd4: begin
            w.alu_op = OP_NEG; w.src_a = SRC_T0; w.dst = DST_T0;
         end
         4'd5: begin
            w.alu_op = OP_NEG; w.src_a = SRC_C; w.dst = DST_T2;
         end
         4'd6: begin
            w.alu_op = OP_ADD; w.src_a = SRC_X; w.src_b = SRC_T2; w.dst = DST_T2;
         end
         4'd7: begin
            w.alu_op = OP_MUL; w.src_a = SRC_Z; w.src_b = SRC_T2;
         end
         4'd8: begin
            w.alu_op = OP_ADD; w.src_a = SRC_B; w.src_b = SRC_P; w.dst = DST_T2;
         end
         4'd9: begin
            w.alu_op = OP_MUL; w.src_a = SRC_H; w.src_b = SRC_T0;
         end
         4'd10: begin
            w.alu_op = OP_ADD; w.src_a = SRC_X; w.src_b = SRC_P; w.dst = DST_X;
         end
         4'd11: begin
            w.alu_op = OP_MUL; w.src_a = SRC_H; w.src_b = SRC_T1;
         end
         4'd12: begin
            w.alu_op = OP_ADD; w.src_a = SRC_Y; w.src_b = SRC_P; w.dst = DST_Y;
         end
         4'd13: begin
            w.alu_op = OP_MUL; w.src_a = SRC_H; w.src_b = SRC_T2;
         end
         4'd14: begin
            w.alu_op = OP_ADD; w.src_a = SRC_Z; w.src_b = SRC_P; w.dst = DST_Z;
         end
         4'd15: begin
            w.emit   = 1'b1;
            w.cond   = JC_OUT_BUSY;
            w.target = 4'd15;
         end
         default: begin
            w.cond = JC_NEVER;
         end
      endcase
      return w;
   endfunction

endpackage

[hdl/ras_csr.sv]
// apb register block for the attractor coefficients
module ras_csr
   import ras_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output coef_set_type              coefs
);

   coef_set_type coefs_ff, coefs_in;
   logic         wr_en;
   logic [1:0]   reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      coefs_in = coefs_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_COEF_A:    coefs_in.coef_a    = csr_pwdata;
            REG_COEF_B:    coefs_in.coef_b    = csr_pwdata;
            REG_COEF_C:    coefs_in.coef_c    = csr_pwdata;
            REG_TIME_STEP: coefs_in.time_step = csr_pwdata;
            default:       coefs_in = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '{coef_a: COEF_A_RESET, coef_b: COEF_B_RESET,
                       coef_c: COEF_C_RESET, time_step: TIME_STEP_RESET};
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COEF_A:    csr_prdata = coefs_ff.coef_a;
         REG_COEF_B:    csr_prdata = coefs_ff.coef_b;
         REG_COEF_C:    csr_prdata = coefs_ff.coef_c;
         REG_TIME_STEP: csr_prdata = coefs_ff.time_step;
         default:       csr_prdata = '0;
      endcase
   end

   assign coefs = coefs_ff;

endmodule

[hdl/ras_sequencer.sv]
// step counter and microcode rom with conditional jumps
module ras_sequencer
   import ras_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          out_busy,
   output ctrl_word_type ctrl
);

   step_type step_ff, step_in;
   logic     take_jump;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      case (ctrl.cond)
         JC_NEVER:    take_jump = 1'b0;
         JC_NO_START: take_jump = !start;
         JC_OUT_BUSY: take_jump = out_busy;
         default:     take_jump = 1'b0;
      endcase
      // last step falls through to zero by wrap
      step_in = take_jump ? ctrl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[hdl/ras_datapath.sv]
// point and scratch registers, shared multiplier and saturating adder
module ras_datapath
   import ras_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_word_type ctrl,
   input  coef_set_type  coefs,
   output value_type     point_x,
   output value_type     point_y,
   output value_type     point_z
);

   value_type x_ff, y_ff, z_ff, x_in, y_in, z_in;
   value_type t0_ff, t1_ff, t2_ff, t0_in, t1_in, t2_in;
   prod_type  prod_ff, prod_in;
   value_type prod_sat;
   value_type opnd_a, opnd_b, alu_out;

   function automatic value_type pick(input logic [3:0] sel, input value_type x,
                                      input value_type y, input value_type z,
                                      input coef_set_type c, input value_type t0,
                                      input value_type t1, input value_type t2,
                                      input value_type p);
      value_type r;
      case (sel)
         SRC_ZERO: r = '0;
         SRC_X:    r = x;
         SRC_Y:    r = y;
         SRC_Z:    r = z;
         SRC_A:    r = c.coef_a;
         SRC_B:    r = c.coef_b;
         SRC_C:    r = c.coef_c;
         SRC_H:    r = c.time_step;
         SRC_T0:   r = t0;
         SRC_T1:   r = t1;
         SRC_T2:   r = t2;
         SRC_P:    r = p;
         default:  r = '0;
      endcase
      return r;
   endfunction

   assign prod_sat = sat_prod(prod_ff);
   assign opnd_a = pick(ctrl.src_a, x_ff, y_ff, z_ff, coefs, t0_ff, t1_ff, t2_ff, prod_sat);
   assign opnd_b = pick(ctrl.src_b, x_ff, y_ff, z_ff, coefs, t0_ff, t1_ff, t2_ff, prod_sat);

   always_comb begin
      prod_in = prod_ff;
      case (ctrl.alu_op)
         OP_MUL: begin
            prod_in = prod_type'(opnd_a) * prod_type'(opnd_b);
            alu_out = '0;
         end
         OP_ADD:  alu_out = sat_add(opnd_a, opnd_b);
         OP_NEG:  alu_out = sat_neg(opnd_a);
         default: alu_out = '0;
      endcase
   end

   always_comb begin
      x_in  = x_ff;
      y_in  = y_ff;
      z_in  = z_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      case (ctrl.dst)
         DST_X:   x_in  = alu_out;
         DST_Y:   y_in  = alu_out;
         DST_Z:   z_in  = alu_out;
         DST_T0:  t0_in = alu_out;
         DST_T1:  t1_in = alu_out;
         DST_T2:  t2_in = alu_out;
         default: x_in  = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= POINT_RESET;
         y_ff <= POINT_RESET;
         z_ff <= POINT_RESET;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      prod_ff <= prod_in;
   end

   assign point_x = x_ff;
   assign point_y = y_ff;
   assign point_z = z_ff;

endmodule

[hdl/roessler_attractor_step_top.sv]
// top level of the roessler attractor euler step block
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready   tdata[0] advance, tdata[7:1] zero
//   rsp       out   rsp_tvalid/rsp_tready   tdata[31:0] new_x, [63:32] new_y, [95:64] new_z
//   csr       in    apb psel/penable        coef_a 0x0, coef_b 0x4, coef_c 0x8, time_step 0xc
//
// a tick runs through one idle step, 14 microcode steps through the one shared
// multiplier and saturating adder, and an emit step that wraps back to idle.
// req_tready is high only in the idle step; a beat with advance low is dropped.
// the emit step holds while the result register is still full.
// synchronous reset restores the coefficients and sets the point to 0.01 per axis.
module roessler_attractor_step_top
   import ras_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // advance
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [3*VALUE_WIDTH-1:0]  rsp_tdata,   // new_x, new_y, new_z
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   coef_set_type  coefs;
   ctrl_word_type ctrl;
   value_type     point_x, point_y, point_z;
   logic          start, out_busy, load_out;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [3*VALUE_WIDTH-1:0] rsp_data_ff;

   assign req_tready = (ctrl.cond == JC_NO_START);
   assign start      = req_tvalid && req_tready && req_tdata[0];
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign load_out   = ctrl.emit && !out_busy;

   ras_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coefs       (coefs)
   );

   ras_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_busy (out_busy),
      .ctrl     (ctrl)
   );

   ras_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .coefs   (coefs),
      .point_x (point_x),
      .point_y (point_y),
      .point_z (point_z)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {point_z, point_y, point_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hdl/ras_checker.sv]
// port-level checks for the roessler step block, bound to the top level
module ras_checker
   import ras_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [7:0]                req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [3*VALUE_WIDTH-1:0]  rsp_tdata,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [31:0]               csr_pwdata,
   input logic [31:0]               csr_prdata,
   input logic                      csr_pready
);

   // a held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // a tick that starts work closes the input until the step is done
   a_busy_after_tick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[0] |=> !req_tready)
      else $error("input open right after a tick");

   // a new result only shows up while the sequencer is away from idle
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a running step");

   // a register reads back what was just written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
      |=> (csr_psel && !csr_pwrite && csr_paddr == $past(csr_paddr))
          |-> csr_prdata == $past(csr_pwdata))
      else $error("register readback mismatch");

endmodule

bind roessler_attractor_step_top ras_checker u_checker (.*);

[bench/roessler_attractor_step_top_tb.sv]
// self-checking testbench for the roessler attractor euler step block
module roessler_attractor_step_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ras_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_TICKS  = 400;

   typedef struct {
      value_type x;
      value_type y;
      value_type z;
   } point_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;   // advance, then zero fill
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [3*VALUE_WIDTH-1:0]  rsp_tdata;        // new_x, new_y, new_z
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   logic [7:0]  pending_beats[$];
   point_type   expected_points[$];
   point_type   position;
   point_type   awaited;
   value_type   coef_shadow[4];

   int unsigned mismatches = 0;
   int unsigned results_checked = 0;
   int unsigned ticks_accepted = 0;
   int unsigned drops_accepted = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   logic [4:0]  stall_phase = '0;
   logic [31:0] stall_pattern = '1;

   roessler_attractor_step_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // saturating q8.24 arithmetic, worked in 64 bits
   function automatic value_type clip(input longint v);
      if (v > longint'(VMAX)) return VMAX;
      if (v < longint'(VMIN)) return VMIN;
      return value_type'(v);
   endfunction

   function automatic value_type qadd(input value_type a, input value_type b);
      return clip(longint'(a) + longint'(b));
   endfunction

   function automatic value_type qneg(input value_type a);
      return clip(-longint'(a));
   endfunction

   // arithmetic shift floors toward minus infinity
   function automatic value_type qmul(input value_type a, input value_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return clip(p >>> FRAC_BITS);
   endfunction

   function automatic point_type euler_step(input point_type p);
      point_type n;
      value_type dx, dy, dz, h;
      h  = coef_shadow[REG_TIME_STEP];
      dx = qneg(qadd(p.y, p.z));
      dy = qadd(p.x, qmul(coef_shadow[REG_COEF_A], p.y));
      dz = qadd(coef_shadow[REG_COEF_B],
                qmul(p.z, qadd(p.x, qneg(coef_shadow[REG_COEF_C]))));
      n.x = qadd(p.x, qmul(h, dx));
      n.y = qadd(p.y, qmul(h, dy));
      n.z = qadd(p.z, qmul(h, dz));
      return n;
   endfunction

   task automatic note_mismatch(input string what, input value_type want,
                                input value_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected %0d (%h), got %0d (%h)", what, want, want, got, got);
   endtask

   // sender: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (burst_left > 0 && pending_beats.size() > 0) begin
            req_tdata <= pending_beats.pop_front();
            req_tvalid <= 1'b1;
            burst_left--;
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
      end
   end

   // receiver: a 32-bit ready pattern, redrawn each time it wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_phase <= '0;
         stall_pattern <= '1;
      end else begin
         stall_phase <= stall_phase + 1'b1;
         if (stall_phase == '1) begin
            case ($urandom_range(0, 2))
               0: stall_pattern <= '1;
               1: stall_pattern <= $urandom | 32'h1;
               default: stall_pattern <= ($urandom & $urandom) | 32'h1;
            endcase
         end
         rsp_tready <= stall_pattern[stall_phase];
      end
   end

   // predict on each accepted tick, check each accepted result beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (req_tdata[0]) begin
               position = euler_step(position);
               expected_points.push_back(position);
               ticks_accepted++;
            end else begin
               drops_accepted++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result beat with no tick pending: %h", rsp_tdata);
            end else begin
               awaited = expected_points.pop_front();
               if (rsp_tdata[VALUE_WIDTH-1:0] !== awaited.x)
                  note_mismatch("new_x", awaited.x, rsp_tdata[VALUE_WIDTH-1:0]);
               if (rsp_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH] !== awaited.y)
                  note_mismatch("new_y", awaited.y, rsp_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]);
               if (rsp_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH] !== awaited.z)
                  note_mismatch("new_z", awaited.z, rsp_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH]);
               results_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic csr_access(input logic [1:0] idx, input logic write,
                             input value_type wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_coefs();
      logic [31:0] rd;
      for (int i = 0; i < 4; i++) begin
         csr_access(2'(i), 1'b0, '0, rd);
         if (value_type'(rd) !== coef_shadow[i])
            note_mismatch($sformatf("register %0d readback", i), coef_shadow[i], rd);
      end
   endtask

   task automatic program_coefs(input value_type a, input value_type b,
                                input value_type c, input value_type h);
      value_type   vals[4];
      logic [31:0] rd;
      vals[REG_COEF_A] = a;
      vals[REG_COEF_B] = b;
      vals[REG_COEF_C] = c;
      vals[REG_TIME_STEP] = h;
      for (int i = 0; i < 4; i++) begin
         csr_access(2'(i), 1'b1, vals[i], rd);
         coef_shadow[i] = vals[i];
      end
      check_coefs();
      settings_used++;
   endtask

   // queue ticks, some with advance low mixed in
   task automatic load_ticks(input int ticks, input int drop_pct);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 99) < drop_pct)
            pending_beats.push_back(8'h00);
         pending_beats.push_back(8'h01);
      end
   endtask

   // wait for every queued tick to be taken and answered, then let the block go idle
   task automatic drain();
      while (pending_beats.size() != 0 || req_tvalid || expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic value_type corner_value();
      case ($urandom_range(0, 6))
         0: return VMIN;
         1: return VMAX;
         2: return '0;
         3: return value_type'(1);
         4: return value_type'(-1);
         5: return value_type'(1 << FRAC_BITS);
         default: return value_type'(-(1 << FRAC_BITS));
      endcase
   endfunction

   function automatic value_type tame_value(input int span);
      return value_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   initial begin
      int ticks_left;
      int n;
      coef_shadow[REG_COEF_A] = COEF_A_RESET;
      coef_shadow[REG_COEF_B] = COEF_B_RESET;
      coef_shadow[REG_COEF_C] = COEF_C_RESET;
      coef_shadow[REG_TIME_STEP] = TIME_STEP_RESET;
      position = '{POINT_RESET, POINT_RESET, POINT_RESET};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients and point, one dropped beat in between
      check_coefs();
      pending_beats.push_back(8'h01);
      pending_beats.push_back(8'h01);
      pending_beats.push_back(8'h00);
      load_ticks(4, 0);
      drain();
      // zero step leaves the point where it is
      program_coefs(COEF_A_RESET, COEF_B_RESET, COEF_C_RESET, '0);
      load_ticks(2, 0);
      drain();
      // smallest negative step, floor of tiny negative products
      program_coefs(value_type'(-1), value_type'(1), value_type'(1), value_type'(-1));
      load_ticks(3, 0);
      drain();
      // negating the most negative c saturates, sums and products overflow
      program_coefs(VMAX, VMIN, VMIN, VMAX);
      load_ticks(3, 0);
      drain();
      program_coefs(VMIN, VMAX, VMAX, VMIN);
      load_ticks(3, 30);
      drain();
      program_coefs(COEF_A_RESET, COEF_B_RESET, COEF_C_RESET, value_type'(1 << FRAC_BITS));
      load_ticks(3, 0);
      drain();

      ticks_left = RANDOM_TICKS;
      while (ticks_left > 0) begin
         n = $urandom_range(8, 40);
         if (n > ticks_left) n = ticks_left;
         case ($urandom_range(0, 3))
            0, 1: program_coefs(tame_value(1 << 25), tame_value(1 << 25),
                                value_type'($urandom_range(0, 1 << 27)),
                                value_type'($urandom_range(0, 1 << 22)));
            2: program_coefs($urandom, $urandom, $urandom, $urandom);
            default: program_coefs(corner_value(), corner_value(), corner_value(),
                                   corner_value());
         endcase
         load_ticks(n, 8);
         drain();
         ticks_left -= n;
      end

      $display("%0d ticks and %0d dropped beats over %0d coefficient settings",
               ticks_accepted, drops_accepted, settings_used);
      $display("%0d result beats checked, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
